// ----- hw/rtl/xkc_pkg.sv -----
// Shared types and constants for the keyed XOR stream cipher with checksum tag.
package xkc_pkg;

    // Byte counts of key, IV and tag
    localparam int unsigned KEY_BYTES = 32;
    localparam int unsigned IV_BYTES  = 12;
    localparam int unsigned TAG_BYTES = 16;

    // Widths
    localparam int unsigned WORD_W    = 64;
    localparam int unsigned BYTE_W    = 8;
    localparam int unsigned KEY_POS_W = $clog2(KEY_BYTES);
    localparam int unsigned IV_POS_W  = $clog2(IV_BYTES);
    localparam int unsigned CFG_IDX_W = 3;
    localparam int unsigned IV_HI_W   = 32;

    // Checksum fold: sum * 31 is (sum << 5) - sum
    localparam int unsigned CHECK_SHIFT = 5;

    // Tag byte n starts at bit TAG_STEP * n of the checksum
    localparam int unsigned TAG_STEP = 4;

    typedef logic [BYTE_W-1:0] byte_t;
    typedef logic [WORD_W-1:0] word_t;

    // Request command codes
    typedef enum logic
    {
        CMD_ENCRYPT = 1'b0,
        CMD_DECRYPT = 1'b1
    } cmd_t;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_KEY_WORD_0   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_KEY_WORD_1   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_KEY_WORD_2   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_KEY_WORD_3   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_IV_WORD_LOW  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_IV_WORD_HIGH = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_EXP_TAG_LOW  = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_EXP_TAG_HIGH = 3'd7;

endpackage

// ----- hw/rtl/xkc_tag_check.sv -----
// Compares the 16 tag bytes derived from a checksum against the expected tag.
module xkc_tag_check
(
    input  xkc_pkg::word_t sum,
    input  xkc_pkg::word_t exp_tag_low,
    input  xkc_pkg::word_t exp_tag_high,
    output logic           tag_ok
);

    // Checksum with zero bits above, so the top tag byte reads zeros past bit 63
    logic [xkc_pkg::WORD_W+xkc_pkg::BYTE_W-1:0]   sum_ext;
    logic [2*xkc_pkg::WORD_W-1:0]                 exp_tag;
    logic [xkc_pkg::TAG_BYTES-1:0]                byte_eq;

    assign sum_ext = {{xkc_pkg::BYTE_W{1'b0}}, sum};
    assign exp_tag = {exp_tag_high, exp_tag_low};

    // One compare per tag byte; tag bytes overlap by half a byte
    always_comb
    begin
        for (int n = 0; n < int'(xkc_pkg::TAG_BYTES); n++)
        begin
            byte_eq[n] = (sum_ext[n*xkc_pkg::TAG_STEP +: xkc_pkg::BYTE_W]
                          == exp_tag[n*xkc_pkg::BYTE_W +: xkc_pkg::BYTE_W]);
        end
    end

    assign tag_ok = &byte_eq;

endmodule

// ----- hw/rtl/xor_keystream_cipher_with_tag.sv -----
// Keyed XOR byte-stream cipher with 64-bit running checksum and tag check.
// A request passes through the input register, then the result register.
// Throughput: one byte per cycle while out_stall does not hold the result register;
//   the key/IV select, the checksum fold (one 64-bit subtract-add) and the 16-byte
//   tag compare fit between the two registers.
// Reset clears key, IV and expected tag registers, positions, checksum and valids.
module xor_keystream_cipher_with_tag
(
    input  logic                                 clk,
    input  logic                                 rst_n,

    // Configuration write port
    input  logic                                 cfg_write,
    input  logic [xkc_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  xkc_pkg::word_t                       cfg_data,

    // Request channel
    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  logic                                 command,
    input  logic [xkc_pkg::BYTE_W-1:0]           data_byte,
    input  logic                                 is_last,

    // Result channel
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output logic [xkc_pkg::BYTE_W-1:0]           out_byte,
    output logic                                 out_last,
    output xkc_pkg::word_t                       checksum_value,
    output logic                                 tag_match
);

    // Configuration registers
    xkc_pkg::word_t                  key_reg [4];
    xkc_pkg::word_t                  iv_low_reg;
    logic [xkc_pkg::IV_HI_W-1:0]     iv_high_reg;
    xkc_pkg::word_t                  exp_low_reg;
    xkc_pkg::word_t                  exp_high_reg;

    // Stream state
    logic [xkc_pkg::KEY_POS_W-1:0]   key_pos_reg;
    logic [xkc_pkg::KEY_POS_W-1:0]   key_pos_next;
    logic [xkc_pkg::IV_POS_W-1:0]    iv_pos_reg;
    logic [xkc_pkg::IV_POS_W-1:0]    iv_pos_next;
    xkc_pkg::word_t                  sum_reg;
    xkc_pkg::word_t                  sum_next;

    // Input register
    logic                            s1_valid_reg;
    logic                            s1_valid_next;
    xkc_pkg::cmd_t                   s1_cmd_reg;
    xkc_pkg::byte_t                  s1_data_reg;
    logic                            s1_last_reg;

    // Result register
    logic                            out_valid_reg;
    logic                            out_valid_next;
    xkc_pkg::byte_t                  out_byte_reg;
    logic                            out_last_reg;
    xkc_pkg::word_t                  out_sum_reg;
    logic                            out_match_reg;

    // Datapath
    logic                            accept;
    logic                            advance;
    xkc_pkg::byte_t                  key_byte;
    xkc_pkg::byte_t                  iv_byte;
    xkc_pkg::byte_t                  result_byte;
    xkc_pkg::byte_t                  plain_byte;
    xkc_pkg::word_t                  fold_sum;
    logic [2*xkc_pkg::WORD_W-1:0]    iv_vec;
    logic                            tag_ok;
    logic                            match;

    // Handshake: input register moves on when the result register is free or draining
    assign advance  = s1_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall = s1_valid_reg && out_valid_reg && out_stall;
    assign accept   = in_valid && !in_stall;

    assign s1_valid_next  = accept || (s1_valid_reg && !advance);
    assign out_valid_next = advance || (out_valid_reg && out_stall);

    // Keystream byte: key byte at key position XOR IV byte at IV position
    assign iv_vec = {{(2*xkc_pkg::WORD_W-xkc_pkg::WORD_W-xkc_pkg::IV_HI_W){1'b0}},
                     iv_high_reg, iv_low_reg};

    always_comb
    begin
        key_byte = key_reg[key_pos_reg[xkc_pkg::KEY_POS_W-1:3]]
                          [key_pos_reg[2:0]*xkc_pkg::BYTE_W +: xkc_pkg::BYTE_W];
        iv_byte  = iv_vec[iv_pos_reg*xkc_pkg::BYTE_W +: xkc_pkg::BYTE_W];
    end

    assign result_byte = s1_data_reg ^ key_byte ^ iv_byte;
    assign plain_byte  = (s1_cmd_reg == xkc_pkg::CMD_DECRYPT) ? result_byte : s1_data_reg;

    // Checksum fold: sum * 31 + plaintext, then XOR key byte
    assign fold_sum = ((sum_reg << xkc_pkg::CHECK_SHIFT) - sum_reg
                       + {{(xkc_pkg::WORD_W-xkc_pkg::BYTE_W){1'b0}}, plain_byte})
                      ^ {{(xkc_pkg::WORD_W-xkc_pkg::BYTE_W){1'b0}}, key_byte};

    xkc_tag_check u_tag_check
    (
        .sum          (fold_sum),
        .exp_tag_low  (exp_low_reg),
        .exp_tag_high (exp_high_reg),
        .tag_ok       (tag_ok)
    );

    assign match = s1_last_reg && (s1_cmd_reg == xkc_pkg::CMD_DECRYPT) && tag_ok;

    // Next stream state; last byte clears positions and checksum
    always_comb
    begin
        key_pos_next = key_pos_reg;
        iv_pos_next  = iv_pos_reg;
        sum_next     = sum_reg;
        if (advance)
        begin
            if (s1_last_reg)
            begin
                key_pos_next = '0;
                iv_pos_next  = '0;
                sum_next     = '0;
            end
            else
            begin
                key_pos_next = key_pos_reg + 1'b1;
                iv_pos_next  = (iv_pos_reg == xkc_pkg::IV_POS_W'(xkc_pkg::IV_BYTES - 1))
                               ? '0 : iv_pos_reg + 1'b1;
                sum_next     = fold_sum;
            end
        end
    end

    // Control and stream state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            key_pos_reg   <= '0;
            iv_pos_reg    <= '0;
            sum_reg       <= '0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
            key_pos_reg   <= key_pos_next;
            iv_pos_reg    <= iv_pos_next;
            sum_reg       <= sum_next;
        end
    end

    // Configuration register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 4; i++)
            begin
                key_reg[i] <= '0;
            end
            iv_low_reg   <= '0;
            iv_high_reg  <= '0;
            exp_low_reg  <= '0;
            exp_high_reg <= '0;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                xkc_pkg::REG_KEY_WORD_0:   key_reg[0]   <= cfg_data;
                xkc_pkg::REG_KEY_WORD_1:   key_reg[1]   <= cfg_data;
                xkc_pkg::REG_KEY_WORD_2:   key_reg[2]   <= cfg_data;
                xkc_pkg::REG_KEY_WORD_3:   key_reg[3]   <= cfg_data;
                xkc_pkg::REG_IV_WORD_LOW:  iv_low_reg   <= cfg_data;
                xkc_pkg::REG_IV_WORD_HIGH: iv_high_reg  <= cfg_data[xkc_pkg::IV_HI_W-1:0];
                xkc_pkg::REG_EXP_TAG_LOW:  exp_low_reg  <= cfg_data;
                xkc_pkg::REG_EXP_TAG_HIGH: exp_high_reg <= cfg_data;
                default:                   ;
            endcase
        end
    end

    // Input register payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_cmd_reg  <= xkc_pkg::cmd_t'(command);
            s1_data_reg <= data_byte;
            s1_last_reg <= is_last;
        end
    end

    // Result register payload
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_byte_reg  <= result_byte;
            out_last_reg  <= s1_last_reg;
            out_sum_reg   <= fold_sum;
            out_match_reg <= match;
        end
    end

    assign out_valid      = out_valid_reg;
    assign out_byte       = out_byte_reg;
    assign out_last       = out_last_reg;
    assign checksum_value = out_sum_reg;
    assign tag_match      = out_match_reg;

    // Checks
    iv_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
        iv_pos_reg < xkc_pkg::IV_POS_W'(xkc_pkg::IV_BYTES))
        else $error("IV position out of range");

    pos_lockstep: assert property (@(posedge clk) disable iff (!rst_n)
        key_pos_reg[1:0] == iv_pos_reg[1:0])
        else $error("key and IV positions out of step");

    last_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && s1_last_reg) |=>
        (key_pos_reg == '0 && iv_pos_reg == '0 && sum_reg == '0))
        else $error("stream state not cleared after last byte");

    match_on_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_match_reg) |-> out_last_reg)
        else $error("tag match on a byte that is not last");

    stall_needs_full: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (s1_valid_reg && out_valid_reg))
        else $error("request stalled while a register is free");

endmodule

// ----- dv/xor_keystream_cipher_with_tag_tb.sv -----
// Self-checking testbench for the keyed XOR stream cipher with checksum tag.
module xor_keystream_cipher_with_tag_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned    LONG_HOLD      = 200;
    localparam int unsigned    WATCHDOG_LIMIT = 4000;
    localparam int unsigned    MAX_MSG        = 96;
    localparam int unsigned    MAX_SHOWN      = 10;
    localparam int unsigned    NUM_REGS       = 8;
    localparam int unsigned    TAG_W          = 2 * xkc_pkg::WORD_W;
    localparam xkc_pkg::word_t FOLD_MULT      = 64'd31;

    // Position counters and running checksum of the message in progress
    typedef struct packed
    {
        logic [xkc_pkg::KEY_POS_W-1:0] key_pos;
        logic [xkc_pkg::IV_POS_W-1:0]  iv_pos;
        xkc_pkg::word_t                sum;
    } cursor_t;

    // One predicted result
    typedef struct packed
    {
        xkc_pkg::byte_t text;
        logic           last;
        xkc_pkg::word_t sum;
        logic           match;
    } cipher_out_t;

    logic                          clk       = 1'b0;
    logic                          rst_n     = 1'b0;
    logic                          cfg_write = 1'b0;
    logic [xkc_pkg::CFG_IDX_W-1:0] cfg_index = xkc_pkg::REG_KEY_WORD_0;
    xkc_pkg::word_t                cfg_data  = '0;
    logic                          in_valid  = 1'b0;
    xkc_pkg::cmd_t                 command   = xkc_pkg::CMD_ENCRYPT;
    xkc_pkg::byte_t                data_byte = '0;
    logic                          is_last   = 1'b0;
    logic                          out_stall = 1'b0;
    logic                          in_stall;
    logic                          out_valid;
    xkc_pkg::byte_t                out_byte;
    logic                          out_last;
    xkc_pkg::word_t                checksum_value;
    logic                          tag_match;

    // Mirror of the configuration registers
    xkc_pkg::word_t                key_words [4];
    xkc_pkg::word_t                iv_low    = '0;
    logic [xkc_pkg::IV_HI_W-1:0]   iv_high   = '0;
    xkc_pkg::word_t                tag_low   = '0;
    xkc_pkg::word_t                tag_high  = '0;

    cursor_t                       cipher_state = '0;
    cipher_out_t                   predicted_outputs [$];

    // Message under construction
    xkc_pkg::cmd_t                 msg_cmd  [MAX_MSG];
    xkc_pkg::byte_t                msg_data [MAX_MSG];
    int                            msg_len = 0;

    int                            send_idle_pct  = 0;
    int                            recv_stall_pct = 0;
    bit                            hold_armed     = 1'b0;
    int                            hold_count     = 0;
    int                            idle_cycles    = 0;

    int                            mismatches     = 0;
    int                            requests_sent  = 0;
    int                            results_seen   = 0;
    int                            messages_sent  = 0;
    int                            tags_matched   = 0;
    int                            tags_refused   = 0;
    int                            reg_writes     = 0;

    xor_keystream_cipher_with_tag i_dut
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_write      (cfg_write),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .command        (command),
        .data_byte      (data_byte),
        .is_last        (is_last),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .out_byte       (out_byte),
        .out_last       (out_last),
        .checksum_value (checksum_value),
        .tag_match      (tag_match)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // ---------------------------------------------------------------- predictor

    function automatic xkc_pkg::byte_t key_byte_at(logic [xkc_pkg::KEY_POS_W-1:0] pos);
        xkc_pkg::word_t w;
        w = key_words[pos[4:3]];
        return w[8 * pos[2:0] +: 8];
    endfunction

    function automatic xkc_pkg::byte_t iv_byte_at(logic [xkc_pkg::IV_POS_W-1:0] pos);
        if (pos < 8)
            return iv_low[8 * pos[2:0] +: 8];
        return iv_high[8 * pos[1:0] +: 8];
    endfunction

    // Tag byte n is the checksum from bit 4n upward
    function automatic logic tag_agrees(xkc_pkg::word_t sum);
        xkc_pkg::byte_t derived;
        xkc_pkg::byte_t wanted;
        for (int n = 0; n < xkc_pkg::TAG_BYTES; n++)
        begin
            derived = xkc_pkg::byte_t'(sum >> (xkc_pkg::TAG_STEP * n));
            wanted  = (n < 8) ? tag_low[8 * n +: 8] : tag_high[8 * (n - 8) +: 8];
            if (derived != wanted)
                return 1'b0;
        end
        return 1'b1;
    endfunction

    // Encrypt or decrypt one byte and advance the cursor
    function automatic cipher_out_t cipher_step(inout cursor_t cur,
                                                input xkc_pkg::cmd_t cmd,
                                                input xkc_pkg::byte_t data,
                                                input logic last);
        xkc_pkg::byte_t kb;
        xkc_pkg::byte_t plain;
        cipher_out_t    r;
        kb      = key_byte_at(cur.key_pos);
        r.text  = data ^ kb ^ iv_byte_at(cur.iv_pos);
        plain   = (cmd == xkc_pkg::CMD_DECRYPT) ? r.text : data;
        r.last  = last;
        r.sum   = (cur.sum * FOLD_MULT + xkc_pkg::word_t'(plain)) ^ xkc_pkg::word_t'(kb);
        r.match = last && (cmd == xkc_pkg::CMD_DECRYPT) && tag_agrees(r.sum);
        if (last)
            cur = '0;
        else
        begin
            cur.key_pos = cur.key_pos + 1'b1;
            cur.iv_pos  = (cur.iv_pos == xkc_pkg::IV_BYTES - 1) ? '0 : cur.iv_pos + 1'b1;
            cur.sum     = r.sum;
        end
        return r;
    endfunction

    function automatic xkc_pkg::word_t pick_word();
        case ($urandom_range(3))
            0:       return '0;
            1:       return '1;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    // ---------------------------------------------------------------- drivers

    task automatic write_reg(logic [xkc_pkg::CFG_IDX_W-1:0] idx, xkc_pkg::word_t value);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        cfg_write <= 1'b0;
        case (idx)
            xkc_pkg::REG_KEY_WORD_0,
            xkc_pkg::REG_KEY_WORD_1,
            xkc_pkg::REG_KEY_WORD_2,
            xkc_pkg::REG_KEY_WORD_3:   key_words[idx[1:0]] = value;
            xkc_pkg::REG_IV_WORD_LOW:  iv_low   = value;
            xkc_pkg::REG_IV_WORD_HIGH: iv_high  = value[xkc_pkg::IV_HI_W-1:0];
            xkc_pkg::REG_EXP_TAG_LOW:  tag_low  = value;
            xkc_pkg::REG_EXP_TAG_HIGH: tag_high = value;
            default:                   ;
        endcase
        reg_writes++;
        @(posedge clk);
    endtask

    // Offer one request, hold it until accepted, then predict its result
    task automatic send_request(xkc_pkg::cmd_t cmd, xkc_pkg::byte_t data, logic last);
        cipher_out_t predicted;
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid  <= 1'b1;
        command   <= cmd;
        data_byte <= data;
        is_last   <= last;
        do
            @(posedge clk);
        while (in_stall);
        predicted = cipher_step(cipher_state, cmd, data, last);
        predicted_outputs.insert(predicted_outputs.size(), predicted);
        requests_sent++;
    endtask

    task automatic send_message();
        for (int i = 0; i < msg_len; i++)
            send_request(msg_cmd[i], msg_data[i], i == msg_len - 1);
        messages_sent++;
    endtask

    // Stop offering, wait for every outstanding result, let the pipeline empty
    task automatic settle();
        in_valid <= 1'b0;
        while (predicted_outputs.size() != 0)
            @(posedge clk);
        repeat (3) @(posedge clk);
    endtask

    // Load the expected tag that the queued message will produce, or a near miss
    task automatic arm_expected_tag(bit corrupt);
        cursor_t           walk;
        cipher_out_t       r;
        logic [TAG_W-1:0]  tag;
        walk = cipher_state;
        for (int i = 0; i < msg_len; i++)
            r = cipher_step(walk, msg_cmd[i], msg_data[i], i == msg_len - 1);
        for (int n = 0; n < xkc_pkg::TAG_BYTES; n++)
            tag[8 * n +: 8] = xkc_pkg::byte_t'(r.sum >> (xkc_pkg::TAG_STEP * n));
        if (corrupt)
            tag[$urandom_range(TAG_W - 1)] ^= 1'b1;
        write_reg(xkc_pkg::REG_EXP_TAG_LOW, tag[xkc_pkg::WORD_W-1:0]);
        write_reg(xkc_pkg::REG_EXP_TAG_HIGH, tag[TAG_W-1:xkc_pkg::WORD_W]);
    endtask

    task automatic fill_message(int len, xkc_pkg::cmd_t cmd);
        msg_len = len;
        for (int i = 0; i < len; i++)
        begin
            msg_cmd[i]  = cmd;
            msg_data[i] = xkc_pkg::byte_t'($urandom_range(255));
        end
    endtask

    // ---------------------------------------------------------------- monitors

    // Result receiver: one long hold-off when armed, random stalls otherwise
    always @(posedge clk)
    begin
        if (hold_armed && hold_count < LONG_HOLD)
        begin
            out_stall <= 1'b1;
            hold_count++;
        end
        else
            out_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    // Compare each accepted result with the oldest prediction
    always @(posedge clk)
    begin
        cipher_out_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            results_seen++;
            if (out_last && tag_match)
                tags_matched++;
            else if (out_last)
                tags_refused++;
            if (predicted_outputs.size() == 0)
            begin
                if (mismatches < MAX_SHOWN)
                    $display("[%0t] result with no request outstanding: byte %02h sum %016h",
                             $realtime, out_byte, checksum_value);
                mismatches++;
            end
            else
            begin
                want = predicted_outputs.pop_front();
                if (out_byte !== want.text || out_last !== want.last ||
                    checksum_value !== want.sum || tag_match !== want.match)
                begin
                    if (mismatches < MAX_SHOWN)
                    begin
                        $display("[%0t] mismatch: expected byte %02h last %0b sum %016h match %0b",
                                 $realtime, want.text, want.last, want.sum, want.match);
                        $display("    got byte %02h last %0b sum %016h match %0b",
                                 out_byte, out_last, checksum_value, tag_match);
                    end
                    mismatches++;
                end
            end
        end
    end

    // Watchdog: cycles in which neither channel moves anything
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("[%0t] no progress for %0d cycles, %0d results outstanding",
                     $realtime, idle_cycles, predicted_outputs.size());
            $display("** xor_keystream_cipher_with_tag: FAILED **");
            $finish;
        end
    end

    // ---------------------------------------------------------------- tests

    // All registers at reset: keystream zero, all-zero decrypt matches zero tag
    task automatic test_reset_values();
        send_request(xkc_pkg::CMD_ENCRYPT, 8'h00, 1'b0);
        send_request(xkc_pkg::CMD_ENCRYPT, 8'hFF, 1'b1);
        send_request(xkc_pkg::CMD_DECRYPT, 8'h5A, 1'b1);
        send_request(xkc_pkg::CMD_DECRYPT, 8'h00, 1'b1);
        settle();
    endtask

    // Registers at extremes and mixed patterns; message long enough to wrap the IV position
    task automatic test_extremes_and_wrap();
        write_reg(xkc_pkg::REG_KEY_WORD_0, '1);
        write_reg(xkc_pkg::REG_KEY_WORD_1, '0);
        write_reg(xkc_pkg::REG_KEY_WORD_2, 64'hA5A5_A5A5_A5A5_A5A5);
        write_reg(xkc_pkg::REG_KEY_WORD_3, 64'h0123_4567_89AB_CDEF);
        write_reg(xkc_pkg::REG_IV_WORD_LOW, 64'hF0E1_D2C3_B4A5_9687);
        write_reg(xkc_pkg::REG_IV_WORD_HIGH, '1);
        write_reg(xkc_pkg::REG_EXP_TAG_LOW, '1);
        write_reg(xkc_pkg::REG_EXP_TAG_HIGH, '1);
        msg_len = 14;
        for (int i = 0; i < msg_len; i++)
        begin
            msg_cmd[i]  = xkc_pkg::CMD_ENCRYPT;
            msg_data[i] = (i % 2 == 0) ? 8'h00 : 8'hFF;
        end
        send_message();
        settle();
    endtask

    // Command change inside a message, then decrypt with right and wrong tag
    task automatic test_command_mix_and_tags();
        fill_message(4, xkc_pkg::CMD_ENCRYPT);
        msg_cmd[1] = xkc_pkg::CMD_DECRYPT;
        msg_cmd[3] = xkc_pkg::CMD_DECRYPT;
        send_message();
        settle();
        fill_message(3, xkc_pkg::CMD_DECRYPT);
        arm_expected_tag(1'b0);
        send_message();
        settle();
        fill_message(2, xkc_pkg::CMD_DECRYPT);
        arm_expected_tag(1'b1);
        send_message();
        settle();
    endtask

    // Random messages with occasional new keys, IVs and expected tags
    task automatic test_random_traffic(int sender_pct, int receiver_pct, int n_items);
        int            target;
        int            len;
        xkc_pkg::cmd_t cmd;
        send_idle_pct  = sender_pct;
        recv_stall_pct = receiver_pct;
        target = requests_sent + n_items;
        while (requests_sent < target)
        begin
            if ($urandom_range(99) < 25)
            begin
                settle();
                for (int r = 0; r < NUM_REGS; r++)
                    if ($urandom_range(1) == 0)
                        write_reg(xkc_pkg::CFG_IDX_W'(r), pick_word());
            end
            len = ($urandom_range(7) == 0) ? $urandom_range(MAX_MSG, 33)
                                           : $urandom_range(40, 1);
            cmd = xkc_pkg::cmd_t'($urandom_range(1));
            fill_message(len, cmd);
            // a tenth of the messages switch command byte by byte
            if ($urandom_range(9) == 0)
                for (int i = 0; i < len; i++)
                    msg_cmd[i] = xkc_pkg::cmd_t'($urandom_range(1));
            if (msg_cmd[len - 1] == xkc_pkg::CMD_DECRYPT && $urandom_range(99) < 45)
            begin
                settle();
                arm_expected_tag($urandom_range(2) == 0);
            end
            send_message();
        end
        settle();
    endtask

    // Receiver holds off while requests keep coming, so the input side stalls
    task automatic test_backpressure();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_armed     = 1'b1;
        for (int m = 0; m < 3; m++)
        begin
            fill_message(20, xkc_pkg::cmd_t'(m % 2));
            send_message();
        end
        settle();
        hold_armed = 1'b0;
    endtask

    // Sender pauses between messages until every result is back
    task automatic test_drain_pause();
        recv_stall_pct = 30;
        for (int m = 0; m < 4; m++)
        begin
            fill_message($urandom_range(12, 4), xkc_pkg::cmd_t'($urandom_range(1)));
            send_message();
            settle();
        end
    endtask

    initial
    begin
        for (int k = 0; k < 4; k++)
            key_words[k] = '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_values();
        test_extremes_and_wrap();
        test_command_mix_and_tags();
        test_random_traffic(29, 69, 480);
        test_random_traffic(69, 29, 480);
        test_random_traffic(0, 0, 480);
        test_backpressure();
        test_drain_pause();

        settle();
        repeat (6) @(posedge clk);
        if (predicted_outputs.size() != 0)
            mismatches++;

        $display("Run covered %0d requests in %0d messages, %0d results, %0d register writes.",
                 requests_sent, messages_sent, results_seen, reg_writes);
        $display("Message ends: %0d with tag match, %0d without; %0d mismatches.",
                 tags_matched, tags_refused, mismatches);
        if (mismatches == 0)
            $display("** xor_keystream_cipher_with_tag: PASSED **");
        else
            $display("** xor_keystream_cipher_with_tag: FAILED **");
        $finish;
    end

endmodule
